@@ hdl/postfix_stack_evaluator_defines.svh @@
// Assertion shorthands for the postfix evaluator.
// All checks sample on the rising edge of clk and are off while arst_n is low.
`ifndef POSTFIX_STACK_EVALUATOR_DEFINES_SVH
`define POSTFIX_STACK_EVALUATOR_DEFINES_SVH

// Same-cycle implication.
`define PSE_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication.
`define PSE_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

@@ hdl/pse_pkg.sv @@
package pse_pkg;

	localparam int STACK_DEPTH = 128;
	localparam int VAR_COUNT   = 128;
	localparam int WORD_W      = 64;
	localparam int HALF_W      = WORD_W / 2;
	localparam int SHAMT_W     = $clog2(WORD_W);
	localparam int DEPTH_W     = $clog2(STACK_DEPTH + 1);
	localparam int STK_AW      = $clog2(STACK_DEPTH);
	localparam int VAR_AW      = (VAR_COUNT > 1) ? $clog2(VAR_COUNT) : 1;

	// token kinds
	localparam logic [2:0] KIND_PUSH   = 3'd0;
	localparam logic [2:0] KIND_BINOP  = 3'd1;
	localparam logic [2:0] KIND_NOT    = 3'd2;
	localparam logic [2:0] KIND_ASSIGN = 3'd3;
	localparam logic [2:0] KIND_LOAD   = 3'd4;

	// binary operators
	localparam logic [3:0] OP_ADD  = 4'd0;
	localparam logic [3:0] OP_MUL  = 4'd1;
	localparam logic [3:0] OP_SUB  = 4'd2;
	localparam logic [3:0] OP_AND  = 4'd3;
	localparam logic [3:0] OP_OR   = 4'd4;
	localparam logic [3:0] OP_XOR  = 4'd5;
	localparam logic [3:0] OP_SHL  = 4'd6;
	localparam logic [3:0] OP_ASR  = 4'd7;
	localparam logic [3:0] OP_ROTL = 4'd8;
	localparam logic [3:0] OP_ROTR = 4'd9;

	// multiply sequencer steps
	localparam logic [1:0] MSTEP_LL = 2'd0;
	localparam logic [1:0] MSTEP_LH = 2'd1;
	localparam logic [1:0] MSTEP_HL = 2'd2;

	typedef struct packed {
		logic [2:0]               kind;
		logic [3:0]               op;
		logic signed [WORD_W-1:0] literal;
		logic [6:0]               var_index;
		logic                     last;
	} tok_t;

	typedef struct packed {
		logic signed [WORD_W-1:0] value;
		logic                     error;
	} res_t;

endpackage

@@ hdl/postfix_stack_evaluator.sv @@
// Postfix evaluator: takes one token word per handshake on tok (push literal,
// binary op, bitwise not, assign to variable, load variable) and on the token
// marked last, unless it is an assignment, returns one word on res holding the
// bottom stack entry (0 if the stack is empty) and an error flag that is set
// for any underflow or overflow during the expression or a final depth other
// than one. A token first reads the stack memory and the variable memory
// (synchronous read), then computes and writes back; a multiply repeats the
// compute step once per partial product, since the 64-bit product is built from
// three 32x32 partial products on one shared multiplier. The result sits in an
// output register; a new token is held off while one is in flight, or while
// a result waits on a stalled receiver, since that token could end an expression.
`include "postfix_stack_evaluator_defines.svh"

module postfix_stack_evaluator import pse_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic tok_valid,
	output logic tok_stall,
	input  tok_t tok,
	output logic res_valid,
	input  logic res_stall,
	output res_t res
);

	// Top of stack lives in tos_q; memory holds entries below it.
	// bottom_q mirrors entry 0 whenever depth is nonzero.
	logic [WORD_W-1:0]  stk_mem [STACK_DEPTH];
	logic [WORD_W-1:0]  var_mem [VAR_COUNT];
	logic [VAR_COUNT-1:0] var_valid_q;

	logic               busy_q;
	logic [1:0]         step_q;
	logic [DEPTH_W-1:0] depth_q;
	logic               err_q;
	logic [WORD_W-1:0]  tos_q;
	logic [WORD_W-1:0]  bottom_q;
	logic [WORD_W-1:0]  acc_q;
	logic               res_valid_q;
	res_t               res_q;

	tok_t               tok_s1;
	logic               var_ok_s1;
	logic               var_inr_s1;
	logic [WORD_W-1:0]  stk_rd_s1;
	logic [WORD_W-1:0]  var_rd_s1;

	logic               tok_acc;
	logic               res_taken;
	logic               var_inr;
	logic [VAR_AW-1:0]  var_addr;
	logic [VAR_AW-1:0]  var_addr_s1;
	logic [DEPTH_W-1:0] depth_m1;
	logic [DEPTH_W-1:0] depth_m2;
	logic [STK_AW-1:0]  stk_rd_addr;
	logic [STK_AW-1:0]  stk_wr_addr;

	logic [WORD_W-1:0]  opa;
	logic [WORD_W-1:0]  opb;
	logic [SHAMT_W-1:0] shamt;
	logic [2*WORD_W-1:0] rot_l;
	logic [2*WORD_W-1:0] rot_r;
	logic [HALF_W-1:0]  mul_x;
	logic [HALF_W-1:0]  mul_y;
	logic [WORD_W-1:0]  prod;
	logic [WORD_W-1:0]  alu;
	logic               alu_ok;
	logic               mul_go;
	logic               fin;

	logic [WORD_W-1:0]  push_v;
	logic [WORD_W-1:0]  tos_n;
	logic [WORD_W-1:0]  bottom_n;
	logic [DEPTH_W-1:0] depth_n;
	logic               err_n;
	logic               stk_we;
	logic               var_we;
	logic               res_set;

	// ---------------- handshake ----------------
	assign tok_acc   = tok_valid && !tok_stall;
	assign res_taken = res_valid_q && !res_stall;
	// Hold off while a token is in flight, or while an untaken result would
	// collide with the one this token might produce.
	assign tok_stall = busy_q || (res_valid_q && res_stall);
	assign res_valid = res_valid_q;
	assign res       = res_q;

	// ---------------- read phase (accept edge) ----------------
	assign var_inr     = int'(tok.var_index) < VAR_COUNT;
	assign var_addr    = VAR_AW'(tok.var_index);
	assign var_addr_s1 = VAR_AW'(tok_s1.var_index);
	assign depth_m1    = depth_q - DEPTH_W'(1);
	assign depth_m2    = depth_q - DEPTH_W'(2);
	assign stk_rd_addr = depth_m2[STK_AW-1:0];   // entry just below the top
	assign stk_wr_addr = depth_m1[STK_AW-1:0];   // slot the old top moves to

	always_ff @(posedge clk) begin
		if (tok_acc) begin
			stk_rd_s1 <= stk_mem[stk_rd_addr];
		end
		if (stk_we) begin
			stk_mem[stk_wr_addr] <= tos_q;
		end
	end

	always_ff @(posedge clk) begin
		if (tok_acc) begin
			var_rd_s1 <= var_mem[var_addr];
		end
		if (var_we) begin
			var_mem[var_addr_s1] <= tos_q;
		end
	end

	always_ff @(posedge clk) begin
		if (tok_acc) begin
			tok_s1     <= tok;
			var_inr_s1 <= var_inr;
			var_ok_s1  <= var_inr && var_valid_q[var_addr];
		end
	end

	// ---------------- execute phase ----------------
	assign opa   = stk_rd_s1;
	assign opb   = tos_q;
	assign shamt = opb[SHAMT_W-1:0];
	assign rot_l = {opa, opa} << shamt;
	assign rot_r = {opa, opa} >> shamt;

	// Low 64 bits of a*b = aL*bL + ((aL*bH + aH*bL) << 32), one product per step.
	assign mul_go = (tok_s1.kind == KIND_BINOP) && (tok_s1.op == OP_MUL)
		&& (depth_q >= DEPTH_W'(2));

	always_comb begin
		case (step_q)
			MSTEP_LL: begin
				mul_x = opa[HALF_W-1:0];
				mul_y = opb[HALF_W-1:0];
			end
			MSTEP_LH: begin
				mul_x = opa[HALF_W-1:0];
				mul_y = opb[WORD_W-1:HALF_W];
			end
			default: begin
				mul_x = opa[WORD_W-1:HALF_W];
				mul_y = opb[HALF_W-1:0];
			end
		endcase
	end

	assign prod = WORD_W'(mul_x) * WORD_W'(mul_y);

	always_ff @(posedge clk) begin
		if (busy_q && mul_go) begin
			if (step_q == MSTEP_LL) begin
				acc_q <= prod;
			end else begin
				acc_q <= acc_q + {prod[HALF_W-1:0], {HALF_W{1'b0}}};
			end
		end
	end

	// Done this cycle unless the multiply still has steps to run.
	assign fin = busy_q && !(mul_go && (step_q != MSTEP_HL));

	always_comb begin
		alu_ok = 1'b1;
		case (tok_s1.op)
			OP_ADD:  alu = opa + opb;
			OP_MUL:  alu = acc_q + {prod[HALF_W-1:0], {HALF_W{1'b0}}};
			OP_SUB:  alu = opa - opb;
			OP_AND:  alu = opa & opb;
			OP_OR:   alu = opa | opb;
			OP_XOR:  alu = opa ^ opb;
			OP_SHL:  alu = opa << shamt;
			OP_ASR:  alu = $signed(opa) >>> shamt;
			OP_ROTL: alu = rot_l[2*WORD_W-1:WORD_W];
			OP_ROTR: alu = rot_r[WORD_W-1:0];
			default: begin
				// unknown operator: stack left alone, no error
				alu    = opb;
				alu_ok = 1'b0;
			end
		endcase
	end

	assign push_v = (tok_s1.kind == KIND_PUSH) ? tok_s1.literal
		: (var_ok_s1 ? var_rd_s1 : '0);

	always_comb begin
		tos_n    = tos_q;
		bottom_n = bottom_q;
		depth_n  = depth_q;
		err_n    = err_q;
		stk_we   = 1'b0;
		var_we   = 1'b0;
		case (tok_s1.kind) inside
			KIND_PUSH, KIND_LOAD: begin
				if (depth_q == DEPTH_W'(STACK_DEPTH)) begin
					err_n = 1'b1;
				end else begin
					stk_we  = fin && (depth_q != '0);
					tos_n   = push_v;
					depth_n = depth_q + DEPTH_W'(1);
					if (depth_q == '0) begin
						bottom_n = push_v;
					end
				end
			end
			KIND_BINOP: begin
				if (depth_q < DEPTH_W'(2)) begin
					err_n = 1'b1;
				end else if (alu_ok) begin
					tos_n   = alu;
					depth_n = depth_m1;
					if (depth_q == DEPTH_W'(2)) begin
						bottom_n = alu;
					end
				end
			end
			KIND_NOT: begin
				if (depth_q == '0) begin
					err_n = 1'b1;
				end else begin
					tos_n = ~tos_q;
					if (depth_q == DEPTH_W'(1)) begin
						bottom_n = ~tos_q;
					end
				end
			end
			KIND_ASSIGN: begin
				if (depth_q == '0) begin
					err_n = 1'b1;
				end else begin
					var_we  = fin && var_inr_s1;
					tos_n   = opa;            // entry below becomes the top
					depth_n = depth_m1;
				end
			end
			default: ;
		endcase
	end

	assign res_set = fin && tok_s1.last && (tok_s1.kind != KIND_ASSIGN);

	// ---------------- state registers ----------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q      <= 1'b0;
			step_q      <= MSTEP_LL;
			depth_q     <= '0;
			err_q       <= 1'b0;
			res_valid_q <= 1'b0;
			var_valid_q <= '0;
		end else begin
			if (tok_acc) begin
				busy_q <= 1'b1;
			end else if (fin) begin
				busy_q <= 1'b0;
			end

			if (fin) begin
				step_q <= MSTEP_LL;
			end else if (busy_q) begin
				step_q <= step_q + 2'd1;
			end

			if (fin) begin
				depth_q <= tok_s1.last ? '0 : depth_n;
				err_q   <= tok_s1.last ? 1'b0 : err_n;
			end

			if (var_we) begin
				var_valid_q[var_addr_s1] <= 1'b1;
			end

			if (res_set) begin
				res_valid_q <= 1'b1;
			end else if (res_taken) begin
				res_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (fin) begin
			tos_q    <= tos_n;
			bottom_q <= bottom_n;
		end
		if (res_set) begin
			res_q.value <= (depth_n != '0) ? bottom_n : '0;
			res_q.error <= err_n || (depth_n != DEPTH_W'(1));
		end
	end

	// ---------------- checks ----------------
	`PSE_ASSERT_NEXT(a_accept_busy, tok_acc, busy_q, "accepted word not in flight")
	`PSE_ASSERT_NOW(a_busy_res_empty, busy_q, !res_valid_q, "result pending during execute")
	`PSE_ASSERT_NOW(a_depth_bound, 1'b1, depth_q <= DEPTH_W'(STACK_DEPTH), "stack depth overrun")
	`PSE_ASSERT_NOW(a_mul_step, step_q != MSTEP_LL, busy_q && mul_go, "multiply step without multiply")

endmodule
